// ===== design/udpf_pkg.sv =====
// shared types and constants for the udp port and payload filter
`default_nettype none

package udpf_pkg;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] RegTargetPort = 8'd0;
  localparam logic [CfgIdxW-1:0] RegPayloadSig = 8'd1;

  localparam logic [15:0] TargetPortRst = 16'd67;
  localparam logic [31:0] PayloadSigRst = 32'h3501_0106;

  localparam logic [15:0] EthertypeIpv4 = 16'h0800;
  localparam logic [7:0]  ProtoUdp      = 8'd17;
  localparam logic [15:0] MinUdpLength  = 16'd12;

  localparam int unsigned PosW = 6;
  localparam logic [PosW-1:0] PosMax      = 6'd63;
  localparam logic [PosW-1:0] FrameNeeded = 6'd46;

  // byte offsets within the frame
  localparam logic [PosW-1:0] OffEtherLo  = 6'd12;
  localparam logic [PosW-1:0] OffEtherHi  = 6'd13;
  localparam logic [PosW-1:0] OffProto    = 6'd23;
  localparam logic [PosW-1:0] OffSrcIpLo  = 6'd26;
  localparam logic [PosW-1:0] OffSrcIpHi  = 6'd29;
  localparam logic [PosW-1:0] OffDstIpLo  = 6'd30;
  localparam logic [PosW-1:0] OffDstIpHi  = 6'd33;
  localparam logic [PosW-1:0] OffSrcPtLo  = 6'd34;
  localparam logic [PosW-1:0] OffSrcPtHi  = 6'd35;
  localparam logic [PosW-1:0] OffDstPtLo  = 6'd36;
  localparam logic [PosW-1:0] OffDstPtHi  = 6'd37;
  localparam logic [PosW-1:0] OffUdpLenLo = 6'd38;
  localparam logic [PosW-1:0] OffUdpLenHi = 6'd39;
  localparam logic [PosW-1:0] OffPayLo    = 6'd42;
  localparam logic [PosW-1:0] OffPayHi    = 6'd45;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        matched;
    logic [31:0] src_ip;
    logic [15:0] src_port;
    logic [31:0] dst_ip;
    logic [15:0] dst_port;
  } result_t;

  typedef struct packed {
    logic [15:0] target_port;
    logic [31:0] payload_sig;
  } cfg_t;

endpackage

`default_nettype wire

// ===== design/udpf_ifs.sv =====
// handshake interfaces for the byte input, result output and register write channels
`default_nettype none

interface udpf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface udpf_out_if;
  logic        valid;
  logic        ready;
  logic        matched;
  logic [31:0] src_ip;
  logic [15:0] src_port;
  logic [31:0] dst_ip;
  logic [15:0] dst_port;
  modport source (output valid, output matched, output src_ip, output src_port,
                  output dst_ip, output dst_port, input ready);
  modport sink (input valid, input matched, input src_ip, input src_port,
                input dst_ip, input dst_port, output ready);
endinterface

interface udpf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [udpf_pkg::CfgIdxW-1:0]   index;
  logic [udpf_pkg::CfgDataW-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/udpf_ingress.sv =====
// input register stage for incoming frame bytes
`default_nettype none

module udpf_ingress
  import udpf_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  output logic          ready_o,
  input  wire in_item_t item_i,
  input  wire logic     adv_i,
  output logic          valid_o,
  output in_item_t      item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;

  // stage frees up when its byte moves on this cycle
  assign ready_o = !valid_q || adv_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !adv_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ===== design/udpf_parser.sv =====
// header field capture and match check
`default_nettype none

module udpf_parser
  import udpf_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     step_i,
  input  wire in_item_t item_i,
  input  wire cfg_t     cfg_i,
  output logic          load_o,
  output result_t       res_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0] ether_q, ether_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] src_ip_q, src_ip_d;
  logic [31:0] dst_ip_q, dst_ip_d;
  logic [15:0] src_pt_q, src_pt_d;
  logic [15:0] dst_pt_q, dst_pt_d;
  logic [15:0] udp_len_q, udp_len_d;
  logic [31:0] pay_q, pay_d;
  logic [PosW-1:0] p;
  logic [7:0]  b;
  logic        ok;

  assign p = pos_q;
  assign b = item_i.data_byte;

  always_comb begin
    ether_d   = ether_q;
    proto_d   = proto_q;
    src_ip_d  = src_ip_q;
    dst_ip_d  = dst_ip_q;
    src_pt_d  = src_pt_q;
    dst_pt_d  = dst_pt_q;
    udp_len_d = udp_len_q;
    pay_d     = pay_q;
    if (p == OffEtherLo || p == OffEtherHi) begin
      ether_d = {ether_q[7:0], b};
    end else if (p == OffProto) begin
      proto_d = b;
    end else if (p >= OffSrcIpLo && p <= OffSrcIpHi) begin
      src_ip_d = {src_ip_q[23:0], b};
    end else if (p >= OffDstIpLo && p <= OffDstIpHi) begin
      dst_ip_d = {dst_ip_q[23:0], b};
    end else if (p == OffSrcPtLo || p == OffSrcPtHi) begin
      src_pt_d = {src_pt_q[7:0], b};
    end else if (p == OffDstPtLo || p == OffDstPtHi) begin
      dst_pt_d = {dst_pt_q[7:0], b};
    end else if (p == OffUdpLenLo || p == OffUdpLenHi) begin
      udp_len_d = {udp_len_q[7:0], b};
    end else if (p >= OffPayLo && p <= OffPayHi) begin
      pay_d = {pay_q[23:0], b};
    end
    pos_d = (p < PosMax) ? p + 6'd1 : p;
  end

  // checks see the fields with the final byte already shifted in
  assign ok = (pos_d >= FrameNeeded)
           && (ether_d == EthertypeIpv4)
           && (proto_d == ProtoUdp)
           && (dst_pt_d == cfg_i.target_port)
           && (udp_len_d >= MinUdpLength)
           && (pay_d == cfg_i.payload_sig);

  assign load_o         = step_i && item_i.last_byte;
  assign res_o.matched  = ok;
  assign res_o.src_ip   = src_ip_d;
  assign res_o.src_port = src_pt_d;
  assign res_o.dst_ip   = dst_ip_d;
  assign res_o.dst_port = dst_pt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      ether_q   <= '0;
      proto_q   <= '0;
      src_ip_q  <= '0;
      dst_ip_q  <= '0;
      src_pt_q  <= '0;
      dst_pt_q  <= '0;
      udp_len_q <= '0;
      pay_q     <= '0;
    end else if (step_i) begin
      if (item_i.last_byte) begin
        // frame done, start the next one clean
        pos_q     <= '0;
        ether_q   <= '0;
        proto_q   <= '0;
        src_ip_q  <= '0;
        dst_ip_q  <= '0;
        src_pt_q  <= '0;
        dst_pt_q  <= '0;
        udp_len_q <= '0;
        pay_q     <= '0;
      end else begin
        pos_q     <= pos_d;
        ether_q   <= ether_d;
        proto_q   <= proto_d;
        src_ip_q  <= src_ip_d;
        dst_ip_q  <= dst_ip_d;
        src_pt_q  <= src_pt_d;
        dst_pt_q  <= dst_pt_d;
        udp_len_q <= udp_len_d;
        pay_q     <= pay_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/udpf_result_reg.sv =====
// output register holding one result request
`default_nettype none

module udpf_result_reg
  import udpf_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t res_i,
  output logic         free_o,
  output logic         valid_o,
  input  wire logic    ready_i,
  output result_t      res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

// ===== design/udp_port_payload_filter.sv =====
// top level of the udp port and payload filter
//
//  channel  dir  payload                                        request taken when
//  in_s     in   data_byte[7:0], last_byte                      valid && ready
//  out_m    out  matched, src_ip, src_port, dst_ip, dst_port    valid && ready
//  cfg_s    in   index[7:0], data[31:0]                         valid && ready (always ready)
//
// one byte per cycle sustained while the output register can take each result.
// a frame's result is loaded into the output register at the edge where its last
// byte leaves the input register, so it is offered from the output register once
// that byte has passed the input register and the output is free. reset clears
// the frame state and loads register defaults. a stalled output holds a last byte
// in the input register, which then blocks the input; other bytes keep flowing.
`default_nettype none

module udp_port_payload_filter
  import udpf_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  udpf_in_if.sink   in_s,
  udpf_out_if.source out_m,
  udpf_cfg_if.sink  cfg_s
);

  in_item_t in_item, s1_item;
  logic     s1_valid, adv, res_free, res_load, out_valid;
  result_t  res_d, res_q;
  cfg_t     cfg_q;

  assign in_item.data_byte = in_s.data_byte;
  assign in_item.last_byte = in_s.last_byte;

  // a last byte must wait until the output register can take its result
  assign adv = s1_valid && (!s1_item.last_byte || res_free);

  udpf_ingress u_ingress (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_s.valid),
    .ready_o (in_s.ready),
    .item_i  (in_item),
    .adv_i   (adv),
    .valid_o (s1_valid),
    .item_o  (s1_item)
  );

  udpf_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .item_i (s1_item),
    .cfg_i  (cfg_q),
    .load_o (res_load),
    .res_o  (res_d)
  );

  udpf_result_reg u_result (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_load),
    .res_i   (res_d),
    .free_o  (res_free),
    .valid_o (out_valid),
    .ready_i (out_m.ready),
    .res_o   (res_q)
  );

  assign out_m.valid    = out_valid;
  assign out_m.matched  = res_q.matched;
  assign out_m.src_ip   = res_q.src_ip;
  assign out_m.src_port = res_q.src_port;
  assign out_m.dst_ip   = res_q.dst_ip;
  assign out_m.dst_port = res_q.dst_port;

  assign cfg_s.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_port <= TargetPortRst;
      cfg_q.payload_sig <= PayloadSigRst;
    end else if (cfg_s.valid) begin
      case (cfg_s.index)
        RegTargetPort: cfg_q.target_port <= cfg_s.data[15:0];
        RegPayloadSig: cfg_q.payload_sig <= cfg_s.data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// self-checking testbench for the udp port and payload filter
`timescale 1ns / 1ps

module testbench;
  import udpf_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned LongHold   = 400;
  localparam int unsigned ItemTarget = 1750;
  localparam int unsigned QuietFrom  = 1450;
  localparam int unsigned PhaseBytes = 300;

  // byte-level model of the filter and the list of results still owed by the block
  class frame_scoreboard;
    logic [15:0] target_port  = 16'd67;
    logic [31:0] signature    = 32'h3501_0106;
    logic [5:0]  pos          = '0;
    logic [15:0] ethertype    = '0;
    logic [7:0]  protocol     = '0;
    logic [31:0] src_ip       = '0;
    logic [31:0] dst_ip       = '0;
    logic [15:0] src_port     = '0;
    logic [15:0] dst_port     = '0;
    logic [15:0] udp_len      = '0;
    logic [31:0] payload_head = '0;
    result_t     awaited[$];
    int unsigned errors       = 0;

    function void set_register(logic [7:0] idx, logic [31:0] val);
      if (idx == RegTargetPort) target_port = val[15:0];
      else if (idx == RegPayloadSig) signature = val;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      result_t r;
      if (pos == 6'd12 || pos == 6'd13) ethertype = {ethertype[7:0], b};
      else if (pos == 6'd23) protocol = b;
      else if (pos >= 6'd26 && pos <= 6'd29) src_ip = {src_ip[23:0], b};
      else if (pos >= 6'd30 && pos <= 6'd33) dst_ip = {dst_ip[23:0], b};
      else if (pos == 6'd34 || pos == 6'd35) src_port = {src_port[7:0], b};
      else if (pos == 6'd36 || pos == 6'd37) dst_port = {dst_port[7:0], b};
      else if (pos == 6'd38 || pos == 6'd39) udp_len = {udp_len[7:0], b};
      else if (pos >= 6'd42 && pos <= 6'd45) payload_head = {payload_head[23:0], b};
      if (pos != 6'd63) pos = pos + 6'd1;
      if (last) begin
        r.matched  = pos >= 6'd46 && ethertype == EthertypeIpv4 && protocol == ProtoUdp
                     && dst_port == target_port && udp_len >= MinUdpLength
                     && payload_head == signature;
        r.src_ip   = src_ip;
        r.src_port = src_port;
        r.dst_ip   = dst_ip;
        r.dst_port = dst_port;
        awaited.push_back(r);
        pos = '0;
        ethertype = '0;
        protocol = '0;
        src_ip = '0;
        dst_ip = '0;
        src_port = '0;
        dst_port = '0;
        udp_len = '0;
        payload_head = '0;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        $error("result with no frame pending");
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.matched !== want.matched) begin
        $error("matched: expected %0d, got %0d", want.matched, got.matched);
        errors++;
      end
      if (got.src_ip !== want.src_ip) begin
        $error("src_ip: expected %h, got %h", want.src_ip, got.src_ip);
        errors++;
      end
      if (got.src_port !== want.src_port) begin
        $error("src_port: expected %h, got %h", want.src_port, got.src_port);
        errors++;
      end
      if (got.dst_ip !== want.dst_ip) begin
        $error("dst_ip: expected %h, got %h", want.dst_ip, got.dst_ip);
        errors++;
      end
      if (got.dst_port !== want.dst_port) begin
        $error("dst_port: expected %h, got %h", want.dst_port, got.dst_port);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  udpf_in_if  in_if ();
  udpf_out_if out_if ();
  udpf_cfg_if cfg_if ();

  udp_port_payload_filter dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_s  (in_if),
    .out_m (out_if),
    .cfg_s (cfg_if)
  );

  frame_scoreboard sb = new;

  int unsigned bytes_sent    = 0;
  int unsigned idle_cycles   = 0;
  int unsigned send_pct      = 0;
  int unsigned recv_pct      = 0;
  bit          quiet         = 1'b0;
  bit          long_hold_req = 1'b0;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic void put(ref byte_q_t f, input int unsigned idx, input logic [7:0] v);
    if (idx < f.size()) f[idx] = v;
  endfunction

  // random bytes with the header fields laid over them, as far as the length reaches
  function automatic byte_q_t make_udp_frame(int unsigned len, logic [15:0] dport,
                                             logic [15:0] ulen, logic [31:0] sig);
    byte_q_t f;
    for (int unsigned i = 0; i < len; i++) f.push_back(8'($urandom));
    put(f, 12, EthertypeIpv4[15:8]);
    put(f, 13, EthertypeIpv4[7:0]);
    put(f, 23, ProtoUdp);
    put(f, 36, dport[15:8]);
    put(f, 37, dport[7:0]);
    put(f, 38, ulen[15:8]);
    put(f, 39, ulen[7:0]);
    for (int unsigned i = 0; i < 4; i++) put(f, 42 + i, sig[31 - 8 * i -: 8]);
    return f;
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.last_byte <= last;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    sb.note_byte(b, last);
    bytes_sent++;
    if (!quiet && $urandom_range(0, 99) < send_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  task automatic send_frame(byte_q_t f);
    foreach (f[i]) send_byte(f[i], i == f.size() - 1);
  endtask

  task automatic program_register(logic [7:0] idx, logic [31:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    sb.set_register(idx, val);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // stops the input and waits until every result still owed has come back
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_random_frame();
    int unsigned kind;
    int unsigned len;
    int unsigned idx;
    logic [15:0] dport;
    logic [15:0] ulen;
    logic [31:0] sig;
    byte_q_t     f;
    kind  = $urandom_range(0, 99);
    dport = ($urandom_range(0, 9) == 0) ? 16'($urandom) : sb.target_port;
    sig   = ($urandom_range(0, 9) == 0) ? 32'($urandom) : sb.signature;
    ulen  = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 11))
                                        : 16'($urandom_range(12, 65535));
    len   = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 80) : $urandom_range(46, 56);
    if (kind < 55) begin
      f = make_udp_frame(len, dport, ulen, sig);
    end else if (kind < 70) begin
      // corrupt one header or payload byte
      f = make_udp_frame(len, dport, ulen, sig);
      idx = $urandom_range(0, 45);
      f[idx] = f[idx] ^ 8'($urandom_range(1, 255));
    end else if (kind < 90) begin
      f = make_udp_frame($urandom_range(1, 45), dport, ulen, sig);
    end else begin
      repeat ($urandom_range(1, 70)) f.push_back(8'($urandom));
    end
    send_frame(f);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_result({out_if.matched, out_if.src_ip, out_if.src_port,
                       out_if.dst_ip, out_if.dst_port});
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        out_if.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        long_hold_req = 1'b0;
        out_if.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < recv_pct) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    byte_q_t     q;
    int unsigned phase;
    int unsigned phase_start;
    logic [15:0] tp;
    logic [31:0] sig;

    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    out_if.ready    = 1'b0;
    rst_ni          = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frames against the reset register values
    tp  = sb.target_port;
    sig = sb.signature;
    send_frame(make_udp_frame(46, tp, MinUdpLength, sig));
    send_frame(make_udp_frame(46, tp, 16'hFFFF, sig));
    send_frame(make_udp_frame(70, tp, MinUdpLength, sig));
    send_frame(make_udp_frame(45, tp, MinUdpLength, sig));
    send_frame(make_udp_frame(28, tp, MinUdpLength, sig));
    q = {8'hFF};
    send_frame(q);
    q = make_udp_frame(46, tp, MinUdpLength, sig);
    q[13] = q[13] ^ 8'h01;
    send_frame(q);
    q = make_udp_frame(46, tp, MinUdpLength, sig);
    q[23] = ~ProtoUdp;
    send_frame(q);
    send_frame(make_udp_frame(46, tp ^ 16'h8000, MinUdpLength, sig));
    send_frame(make_udp_frame(46, tp, MinUdpLength - 16'd1, sig));
    send_frame(make_udp_frame(46, tp, MinUdpLength, sig ^ 32'h1));
    q = {};
    repeat (46) q.push_back(8'h00);
    send_frame(q);
    q = {};
    repeat (46) q.push_back(8'hFF);
    send_frame(q);

    for (phase = 0; bytes_sent < ItemTarget; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          tp  = 16'h0000;
          sig = 32'h0000_0000;
        end
        1: begin
          tp  = 16'hFFFF;
          sig = 32'hFFFF_FFFF;
        end
        default: begin
          tp  = 16'($urandom);
          sig = 32'($urandom);
        end
      endcase
      program_register(RegTargetPort, {16'h0000, tp});
      program_register(RegPayloadSig, sig);
      if (phase % 3 == 2) program_register(8'($urandom_range(2, 255)), 32'($urandom));
      quiet    = bytes_sent >= QuietFrom;
      send_pct = (phase % 4 == 3) ? 0 : $urandom_range(5, 30);
      recv_pct = (phase % 4 == 1) ? 0 : $urandom_range(5, 30);
      if (phase == 2) begin
        // tiny frames while results are held back, so the input backs up
        long_hold_req = 1'b1;
        repeat (30) begin
          q = {};
          repeat ($urandom_range(1, 2)) q.push_back(8'($urandom));
          send_frame(q);
        end
      end
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes) send_random_frame();
    end

    wait_drained();
    repeat (16) @(posedge clk_i);
    if (sb.awaited.size() != 0) begin
      $error("%0d results never arrived", sb.awaited.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
